// File: rtl/cltok_pkg.sv
// Shared types and character codes for the command line tokenizer.
// Used by cltok_core and command_line_tokenizer; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cltok_pkg;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_TOKEN = 1'b1;

  // Result queue: room for two items' worth of results.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_out;
    logic [11:0] token_start;
    logic [12:0] token_end;
    logic        last_result;
  } result_t;

  // Results caused by one item: count is 0, 1 or 2, filled from res0.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_t;

endpackage

`default_nettype wire

// File: rtl/cltok_core.sv
// Tokenizer state and the per-byte step logic that forms up to two results.
// Depends on cltok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cltok_core #(
  parameter int LINE_MAX  = 4096,
  parameter int MAX_DEPTH = 255
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    char_in,
  input  wire logic          line_end,
  output cltok_pkg::step_t   step
);

  localparam int POS_W = $clog2(LINE_MAX + 1);
  localparam int SP_W  = $clog2(LINE_MAX);
  localparam int DW    = $clog2(MAX_DEPTH + 1) + 1;

  localparam logic [POS_W-1:0]      POS_MAX  = POS_W'(LINE_MAX);
  localparam logic [POS_W-1:0]      POS_LAST = POS_W'(LINE_MAX - 1);
  localparam logic [SP_W-1:0]       SP_MAX   = SP_W'(LINE_MAX - 1);
  localparam logic signed [DW-1:0]  DEPTH_HI = DW'(MAX_DEPTH);
  localparam logic signed [DW-1:0]  DEPTH_LO = -DW'(MAX_DEPTH);

  logic [POS_W-1:0]     position, position_next;
  logic [SP_W-1:0]      start_pos, start_pos_next;
  logic                 start_valid, start_valid_next;
  logic                 token_nonempty, token_nonempty_next;
  logic                 in_quote, in_quote_next;
  logic                 escape_pending, escape_pending_next;
  logic signed [DW-1:0] nest_depth, nest_depth_next;

  logic               is_space;
  logic               append;
  logic               split;
  logic               flush;
  logic [SP_W-1:0]    sp_eff;
  logic               sv_eff;
  logic               ne_eff;
  logic [POS_W-1:0]   pos_inc;
  cltok_pkg::result_t byte_res;
  cltok_pkg::result_t split_res;
  cltok_pkg::result_t flush_res;
  cltok_pkg::result_t first_res;

  always_comb begin
    is_space = (char_in == cltok_pkg::CH_SPACE);

    sp_eff = start_pos;
    sv_eff = start_valid;
    if (!start_valid && !is_space) begin
      sp_eff = (position < POS_LAST) ? position[SP_W-1:0] : SP_MAX;
      sv_eff = 1'b1;
    end

    append              = 1'b0;
    split               = 1'b0;
    escape_pending_next = escape_pending;
    in_quote_next       = in_quote;
    nest_depth_next     = nest_depth;
    if (escape_pending) begin
      escape_pending_next = 1'b0;
      append              = 1'b1;
    end else if (char_in == cltok_pkg::CH_BACKSLASH && in_quote) begin
      escape_pending_next = 1'b1;
      append              = 1'b1;
    end else if (char_in == cltok_pkg::CH_QUOTE) begin
      in_quote_next = !in_quote;
      append        = 1'b1;
    end else if (!in_quote && (char_in == cltok_pkg::CH_LBRACKET ||
                               char_in == cltok_pkg::CH_LBRACE)) begin
      if (nest_depth < DEPTH_HI) begin
        nest_depth_next = nest_depth + DW'(1);
      end
      append = 1'b1;
    end else if (!in_quote && (char_in == cltok_pkg::CH_RBRACKET ||
                               char_in == cltok_pkg::CH_RBRACE)) begin
      if (nest_depth > DEPTH_LO) begin
        nest_depth_next = nest_depth - DW'(1);
      end
      append = 1'b1;
    end else if (!in_quote && nest_depth == '0 && is_space) begin
      split = token_nonempty;
    end else begin
      append = 1'b1;
    end

    // A splitting space closes the token; an appended byte opens or extends one.
    ne_eff = token_nonempty;
    if (split) begin
      ne_eff = 1'b0;
      sv_eff = 1'b0;
    end
    if (append) begin
      ne_eff = 1'b1;
    end

    pos_inc = (position < POS_MAX) ? position + POS_W'(1) : position;
    flush   = line_end && ne_eff;

    byte_res             = '0;
    byte_res.kind        = cltok_pkg::KIND_BYTE;
    byte_res.char_out    = char_in;

    split_res             = '0;
    split_res.kind        = cltok_pkg::KIND_TOKEN;
    split_res.token_start = 12'(sp_eff);
    split_res.token_end   = 13'(position);

    flush_res             = '0;
    flush_res.kind        = cltok_pkg::KIND_TOKEN;
    flush_res.token_start = 12'(sp_eff);
    flush_res.token_end   = 13'(pos_inc);
    flush_res.last_result = 1'b1;

    first_res             = split ? split_res : byte_res;
    first_res.last_result = !flush;

    step = '0;
    if (append || split) begin
      step.res0  = first_res;
      step.res1  = flush_res;
      step.count = flush ? 2'd2 : 2'd1;
    end else if (flush) begin
      step.res0  = flush_res;
      step.count = 2'd1;
    end

    position_next       = pos_inc;
    start_pos_next      = sp_eff;
    start_valid_next    = sv_eff;
    token_nonempty_next = ne_eff;
    if (line_end) begin
      position_next       = '0;
      start_pos_next      = '0;
      start_valid_next    = 1'b0;
      token_nonempty_next = 1'b0;
      in_quote_next       = 1'b0;
      escape_pending_next = 1'b0;
      nest_depth_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      start_pos      <= '0;
      start_valid    <= 1'b0;
      token_nonempty <= 1'b0;
      in_quote       <= 1'b0;
      escape_pending <= 1'b0;
      nest_depth     <= '0;
    end else if (take) begin
      position       <= position_next;
      start_pos      <= start_pos_next;
      start_valid    <= start_valid_next;
      token_nonempty <= token_nonempty_next;
      in_quote       <= in_quote_next;
      escape_pending <= escape_pending_next;
      nest_depth     <= nest_depth_next;
    end
  end

`ifndef SYNTHESIS
  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && line_end |=> position == '0 && !in_quote && !escape_pending &&
                         nest_depth == '0 && !token_nonempty)
    else $error("state not cleared after the final byte of a line");

  a_depth_bounds: assert property (@(posedge clk) disable iff (rst)
    nest_depth <= DEPTH_HI && nest_depth >= DEPTH_LO)
    else $error("bracket depth out of range");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= POS_MAX && (!token_nonempty || start_valid))
    else $error("position overflow or token without a start");
`endif

endmodule

`default_nettype wire

// File: rtl/command_line_tokenizer.sv
// An item's results enter the result queue as it is taken and are readable in the next cycle.
// Throughput: one item per cycle while each item gives at most one result and results are
// taken as offered; an item that gives a byte and a finished token puts two results in the queue.
// The four-entry result queue sets the rate: an item is taken while at least two entries are free.
// Synchronous active-high reset clears the tokenizer state and empties the queue.
// Depends on cltok_pkg and cltok_core.
`timescale 1ns / 1ps
`default_nettype none

module command_line_tokenizer #(
  parameter int LINE_MAX  = 4096,
  parameter int MAX_DEPTH = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_ready,
  input  wire logic [7:0]  char_in,
  input  wire logic        line_end,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             kind,
  output logic [7:0]       char_out,
  output logic [11:0]      token_start,
  output logic [12:0]      token_end,
  output logic             last_result
);

  localparam int QA = cltok_pkg::Q_AW;
  localparam int QC = cltok_pkg::Q_CW;

  logic               take;
  logic               pop;
  cltok_pkg::step_t   step;
  cltok_pkg::result_t queue [cltok_pkg::Q_DEPTH];
  cltok_pkg::result_t head_res;
  logic [QA-1:0]      head, head_next;
  logic [QA-1:0]      tail, tail_next;
  logic [QA-1:0]      tail_plus;
  logic [QC-1:0]      count, count_next;
  logic [QC-1:0]      pushed;

  cltok_core #(
    .LINE_MAX  (LINE_MAX),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .char_in  (char_in),
    .line_end (line_end),
    .step     (step)
  );

  assign char_ready   = (count <= QC'(cltok_pkg::Q_DEPTH - 2));
  assign take         = char_valid && char_ready;
  assign result_valid = (count != '0);
  assign pop          = result_valid && result_ready;

  assign head_res    = queue[head];
  assign kind        = head_res.kind;
  assign char_out    = head_res.char_out;
  assign token_start = head_res.token_start;
  assign token_end   = head_res.token_end;
  assign last_result = head_res.last_result;

  always_comb begin
    pushed     = take ? QC'(step.count) : '0;
    tail_plus  = tail + QA'(1);
    tail_next  = tail + QA'(pushed);
    head_next  = pop ? head + QA'(1) : head;
    count_next = count + pushed - (pop ? QC'(1) : QC'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && step.count != 2'd0) begin
      queue[tail] <= step.res0;
    end
    if (take && step.count == 2'd2) begin
      queue[tail_plus] <= step.res1;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC'(cltok_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == cltok_pkg::KIND_BYTE |-> token_start == '0 && token_end == '0)
    else $error("byte result carries token positions");

  a_token_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == cltok_pkg::KIND_TOKEN |-> char_out == '0)
    else $error("token result carries a byte");
`endif

endmodule

`default_nettype wire
